// ===== design/polynomial_surface_render_defines.svh =====
// Assertion macros shared by the checker
`ifndef POLYNOMIAL_SURFACE_RENDER_DEFINES_SVH
`define POLYNOMIAL_SURFACE_RENDER_DEFINES_SVH

// Property checked outside reset
`define PSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that also looks at the reset cycle itself
`define PSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/psr_pkg.sv =====
`timescale 1ns / 1ps

package psr_pkg;

  // Q0.24 powers and scaled coordinates, 1.0 included
  localparam int QF = 24;
  localparam int QW = 25;
  localparam int unsigned Q_ONE  = 32'h0100_0000;
  localparam int unsigned Q_HALF = 32'h0080_0000;

  localparam int IDX_W  = 4;
  localparam int GRAY_W = 8;
  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HOR_DEGREE  = 2'd0,
    CFG_VERT_DEGREE = 2'd1,
    CFG_X_SCALE     = 2'd2,
    CFG_Y_SCALE     = 2'd3
  } psr_cfg_reg_t;

  // Control part of a beat moving down the chain
  typedef struct packed {
    logic             valid;
    logic             is_pix;
    logic [IDX_W-1:0] idx;
  } psr_ctl_t;

endpackage

// ===== design/psr_power_cell.sv =====
`timescale 1ns / 1ps

// One power step: p[K] = round(p[K-1] * c) for both coordinates
module psr_power_cell import psr_pkg::*; #(
  parameter int K           = 1,
  parameter int MAX_DEGREE  = 3,
  parameter int COEFF_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  psr_ctl_t                      ctl_in,
  input  logic signed [COEFF_WIDTH-1:0] coeff_in,
  input  logic [QW-1:0]                 cx_in,
  input  logic [QW-1:0]                 cy_in,
  input  logic [MAX_DEGREE:0][QW-1:0]   px_in,
  input  logic [MAX_DEGREE:0][QW-1:0]   py_in,
  output psr_ctl_t                      ctl_r,
  output logic signed [COEFF_WIDTH-1:0] coeff_r,
  output logic [QW-1:0]                 cx_r,
  output logic [QW-1:0]                 cy_r,
  output logic [MAX_DEGREE:0][QW-1:0]   px_r,
  output logic [MAX_DEGREE:0][QW-1:0]   py_r
);

  logic [2*QW-1:0] xprod, yprod, xrnd, yrnd;
  logic [MAX_DEGREE:0][QW-1:0] px_nxt, py_nxt;

  // Rounded Q0.24 products; result never exceeds 1.0
  always_comb begin
    xprod  = (2*QW)'(px_in[K-1]) * (2*QW)'(cx_in);
    yprod  = (2*QW)'(py_in[K-1]) * (2*QW)'(cy_in);
    xrnd   = xprod + (2*QW)'(Q_HALF);
    yrnd   = yprod + (2*QW)'(Q_HALF);
    px_nxt = px_in;
    py_nxt = py_in;
    px_nxt[K] = xrnd[QF +: QW];
    py_nxt[K] = yrnd[QF +: QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coeff_r <= coeff_in;
      cx_r    <= cx_in;
      cy_r    <= cy_in;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
    end
  end

endmodule

// ===== design/psr_term_cell.sv =====
`timescale 1ns / 1ps

// Holds coefficient slot N and adds its term to the passing sum (two stages)
module psr_term_cell import psr_pkg::*; #(
  parameter int N           = 0,
  parameter int MAX_DEGREE  = 3,
  parameter int COEFF_WIDTH = 32,
  parameter int ACW         = 37
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [1:0]                    hd,
  input  logic [1:0]                    vd,
  input  psr_ctl_t                      ctl_in,
  input  logic signed [COEFF_WIDTH-1:0] coeff_in,
  input  logic [MAX_DEGREE:0][QW-1:0]   px_in,
  input  logic [MAX_DEGREE:0][QW-1:0]   py_in,
  input  logic signed [ACW-1:0]         acc_in,
  output psr_ctl_t                      ctl_r,
  output logic signed [COEFF_WIDTH-1:0] coeff_r,
  output logic [MAX_DEGREE:0][QW-1:0]   px_r,
  output logic [MAX_DEGREE:0][QW-1:0]   py_r,
  output logic signed [ACW-1:0]         acc_r
);

  localparam int CW  = COEFF_WIDTH;
  localparam int PRW = CW + QW + 1;
  localparam int IXW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;

  logic signed [CW-1:0] coef_r;

  // stage A registers
  psr_ctl_t                    a_ctl_r;
  logic signed [CW-1:0]        a_coeff_r;
  logic [MAX_DEGREE:0][QW-1:0] a_px_r, a_py_r;
  logic signed [ACW-1:0]       a_acc_r;
  logic signed [CW-1:0]        a_t_r;

  int             ti, tj;
  logic           term_on;
  logic [IXW-1:0] yi, xj;
  logic signed [PRW-1:0] prod_a, rnd_a, prod_b, rnd_b;
  logic signed [CW-1:0]  t_nxt, term_b;
  logic signed [ACW-1:0] acc_nxt;
  logic                  load_hit;

  // Slot N maps to powers (N / (hd+1), N % (hd+1))
  always_comb begin
    case (hd)
      2'd0:    begin ti = N;     tj = 0;     end
      2'd1:    begin ti = N / 2; tj = N % 2; end
      2'd2:    begin ti = N / 3; tj = N % 3; end
      default: begin ti = N / 4; tj = N % 4; end
    endcase
    term_on = (ti <= int'(vd)) && (ti <= MAX_DEGREE) && (tj <= MAX_DEGREE);
    yi = term_on ? IXW'(ti) : '0;
    xj = term_on ? IXW'(tj) : '0;
  end

  assign load_hit = ctl_in.valid && (ctl_in.is_pix == REQ_LOAD) && (int'(ctl_in.idx) == N);

  // coefficient times y power, rounded
  always_comb begin
    prod_a = coef_r * $signed({1'b0, py_in[yi]});
    rnd_a  = prod_a + PRW'(Q_HALF);
    t_nxt  = $signed(rnd_a[QF +: CW]);
  end

  // times x power, rounded, then accumulate
  always_comb begin
    prod_b  = a_t_r * $signed({1'b0, a_px_r[xj]});
    rnd_b   = prod_b + PRW'(Q_HALF);
    term_b  = $signed(rnd_b[QF +: CW]);
    acc_nxt = a_acc_r;
    if (term_on && a_ctl_r.is_pix) begin
      acc_nxt = a_acc_r + ACW'(term_b);
    end
  end

  // control and coefficient state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= '0;
      a_ctl_r <= '0;
      ctl_r   <= '0;
    end else if (en) begin
      if (load_hit) begin
        coef_r <= coeff_in;
      end
      a_ctl_r <= ctl_in;
      ctl_r   <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_coeff_r <= coeff_in;
      a_px_r    <= px_in;
      a_py_r    <= py_in;
      a_acc_r   <= acc_in;
      a_t_r     <= t_nxt;
      coeff_r   <= a_coeff_r;
      px_r      <= a_px_r;
      py_r      <= a_py_r;
      acc_r     <= acc_nxt;
    end
  end

endmodule

// ===== design/polynomial_surface_render.sv =====
`timescale 1ns / 1ps

// Channel | Handshake          | Beat contents
// in      | in_valid/in_stall  | req_type, coeff_index, coeff_value, pixel_x, pixel_y
// out     | out_valid/out_stall| gray_level (one beat per pixel request)
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (ready always high)
//
// One item per clock while the chain is not frozen. From accept to out_valid
// a request passes the scale stage, the power cells, two stages per
// coefficient cell, the gray register and the queue write. Loads travel the
// same chain.
// Synchronous active-low reset clears config, coefficients and valid state.
// A two-beat output queue absorbs out_stall; the chain freezes only when the
// queue is full and a result is waiting to enter it.
module polynomial_surface_render import psr_pkg::*; #(
  parameter int MAX_DEGREE  = 3,
  parameter int COORD_WIDTH = 12,
  parameter int COEFF_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [IDX_W-1:0]              in_coeff_index,
  input  logic signed [COEFF_WIDTH-1:0] in_coeff_value,
  input  logic [COORD_WIDTH-1:0]        in_pixel_x,
  input  logic [COORD_WIDTH-1:0]        in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [GRAY_W-1:0]             out_gray_level,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [QW-1:0]                 cfg_data
);

  localparam int CELLS   = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
  localparam int ACW_RAW = COEFF_WIDTH + $clog2(CELLS) + 1;
  localparam int ACW     = (ACW_RAW > QW + 1) ? ACW_RAW : QW + 2;
  localparam int SW      = COORD_WIDTH + QW;

  // configuration
  logic [1:0]    hor_degree_r, vert_degree_r;
  logic [QW-1:0] x_scale_r, y_scale_r;
  logic [1:0]    hd, vd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hor_degree_r  <= '0;
      vert_degree_r <= '0;
      x_scale_r     <= '0;
      y_scale_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (psr_cfg_reg_t'(cfg_index))
        CFG_HOR_DEGREE:  hor_degree_r  <= cfg_data[1:0];
        CFG_VERT_DEGREE: vert_degree_r <= cfg_data[1:0];
        CFG_X_SCALE:     x_scale_r     <= cfg_data;
        CFG_Y_SCALE:     y_scale_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hd = (int'(hor_degree_r) > MAX_DEGREE) ? 2'(MAX_DEGREE) : hor_degree_r;
  assign vd = (int'(vert_degree_r) > MAX_DEGREE) ? 2'(MAX_DEGREE) : vert_degree_r;

  // chain enable
  logic       en;
  logic       o_vpix_r;
  logic [1:0] cnt_r;

  assign en       = !(o_vpix_r && (cnt_r == 2'd2));
  assign in_stall = !en;

  // scale stage: c' = min(pixel * scale, 1.0)
  psr_ctl_t                      s_ctl_r;
  logic signed [COEFF_WIDTH-1:0] s_coeff_r;
  logic [QW-1:0]                 s_cx_r, s_cy_r;
  logic [MAX_DEGREE:0][QW-1:0]   s_pw_r;
  logic [MAX_DEGREE:0][QW-1:0]   pw_init;
  logic [SW-1:0]                 cx_full, cy_full;
  logic [QW-1:0]                 cx_sat, cy_sat;
  psr_ctl_t                      in_ctl;

  always_comb begin
    cx_full = SW'(in_pixel_x) * SW'(x_scale_r);
    cy_full = SW'(in_pixel_y) * SW'(y_scale_r);
    cx_sat  = (cx_full > SW'(Q_ONE)) ? QW'(Q_ONE) : cx_full[QW-1:0];
    cy_sat  = (cy_full > SW'(Q_ONE)) ? QW'(Q_ONE) : cy_full[QW-1:0];
    pw_init    = '0;
    pw_init[0] = QW'(Q_ONE);
    in_ctl.valid  = in_valid;
    in_ctl.is_pix = (in_req_type == REQ_PIXEL);
    in_ctl.idx    = in_coeff_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_ctl_r <= '0;
    end else if (en) begin
      s_ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_coeff_r <= in_coeff_value;
      s_cx_r    <= cx_sat;
      s_cy_r    <= cy_sat;
      s_pw_r    <= pw_init;
    end
  end

  // power cells
  psr_ctl_t                      p_ctl   [MAX_DEGREE+1];
  logic signed [COEFF_WIDTH-1:0] p_coeff [MAX_DEGREE+1];
  logic [QW-1:0]                 p_cx    [MAX_DEGREE+1];
  logic [QW-1:0]                 p_cy    [MAX_DEGREE+1];
  logic [MAX_DEGREE:0][QW-1:0]   p_px    [MAX_DEGREE+1];
  logic [MAX_DEGREE:0][QW-1:0]   p_py    [MAX_DEGREE+1];

  assign p_ctl[0]   = s_ctl_r;
  assign p_coeff[0] = s_coeff_r;
  assign p_cx[0]    = s_cx_r;
  assign p_cy[0]    = s_cy_r;
  assign p_px[0]    = s_pw_r;
  assign p_py[0]    = s_pw_r;

  for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_pow
    psr_power_cell #(
      .K(k), .MAX_DEGREE(MAX_DEGREE), .COEFF_WIDTH(COEFF_WIDTH)
    ) u_pow (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_in(p_ctl[k-1]), .coeff_in(p_coeff[k-1]),
      .cx_in(p_cx[k-1]), .cy_in(p_cy[k-1]),
      .px_in(p_px[k-1]), .py_in(p_py[k-1]),
      .ctl_r(p_ctl[k]), .coeff_r(p_coeff[k]),
      .cx_r(p_cx[k]), .cy_r(p_cy[k]),
      .px_r(p_px[k]), .py_r(p_py[k])
    );
  end

  // coefficient cells
  psr_ctl_t                      t_ctl   [CELLS+1];
  logic signed [COEFF_WIDTH-1:0] t_coeff [CELLS+1];
  logic [MAX_DEGREE:0][QW-1:0]   t_px    [CELLS+1];
  logic [MAX_DEGREE:0][QW-1:0]   t_py    [CELLS+1];
  logic signed [ACW-1:0]         t_acc   [CELLS+1];

  assign t_ctl[0]   = p_ctl[MAX_DEGREE];
  assign t_coeff[0] = p_coeff[MAX_DEGREE];
  assign t_px[0]    = p_px[MAX_DEGREE];
  assign t_py[0]    = p_py[MAX_DEGREE];
  assign t_acc[0]   = '0;

  for (genvar n = 0; n < CELLS; n++) begin : g_term
    psr_term_cell #(
      .N(n), .MAX_DEGREE(MAX_DEGREE), .COEFF_WIDTH(COEFF_WIDTH), .ACW(ACW)
    ) u_term (
      .clk(clk), .rst_n(rst_n), .en(en), .hd(hd), .vd(vd),
      .ctl_in(t_ctl[n]), .coeff_in(t_coeff[n]),
      .px_in(t_px[n]), .py_in(t_py[n]), .acc_in(t_acc[n]),
      .ctl_r(t_ctl[n+1]), .coeff_r(t_coeff[n+1]),
      .px_r(t_px[n+1]), .py_r(t_py[n+1]), .acc_r(t_acc[n+1])
    );
  end

  // gray conversion: clamp, times 255, round
  logic signed [ACW-1:0] acc;
  logic [QW-1:0]         v;
  logic [QW+7:0]         sc, sr;
  logic [8:0]            gw;
  logic [GRAY_W-1:0]     gray_nxt, o_gray_r;

  always_comb begin
    acc = t_acc[CELLS];
    v   = acc[QW-1:0];
    sc  = {v, 8'b0} - (QW+8)'(v);
    sr  = sc + (QW+8)'(Q_HALF);
    gw  = sr[QF +: 9];
    if (acc[ACW-1]) begin
      gray_nxt = '0;
    end else if (|acc[ACW-2:QW]) begin
      gray_nxt = GRAY_MAX;
    end else if (gw[8]) begin
      gray_nxt = GRAY_MAX;
    end else begin
      gray_nxt = gw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vpix_r <= 1'b0;
    end else if (en) begin
      o_vpix_r <= t_ctl[CELLS].valid && t_ctl[CELLS].is_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_gray_r <= gray_nxt;
    end
  end

  // two-beat output queue
  logic [GRAY_W-1:0] q_mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic              push, pop;

  assign push           = en && o_vpix_r;
  assign pop            = out_valid && !out_stall;
  assign out_valid      = (cnt_r != 2'd0);
  assign out_gray_level = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= o_gray_r;
    end
  end

endmodule

// ===== design/psr_checker.sv =====
`timescale 1ns / 1ps
`include "polynomial_surface_render_defines.svh"

// Port-level checks on the renderer
module psr_checker #(
  parameter int COORD_WIDTH = 12,
  parameter int COEFF_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_req_type,
  input logic [3:0]                    in_coeff_index,
  input logic signed [COEFF_WIDTH-1:0] in_coeff_value,
  input logic [COORD_WIDTH-1:0]        in_pixel_x,
  input logic [COORD_WIDTH-1:0]        in_pixel_y,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [7:0]                    out_gray_level,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [1:0]                    cfg_index,
  input logic [24:0]                   cfg_data
);

  // a held result stays offered
  `PSR_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")
  // and keeps its value
  `PSR_ASSERT(a_out_stable, (out_valid && out_stall) |=> $stable(out_gray_level), "result changed while stalled")
  // input backpressure only comes from a waiting result
  `PSR_ASSERT(a_stall_cause, in_stall |-> out_valid, "input stalled with empty output")
  // reset empties the output side
  `PSR_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind polynomial_surface_render psr_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .COEFF_WIDTH(COEFF_WIDTH)
) u_psr_checker (.*);
